// ===== rtl/expts_pkg.sv =====
// expts_pkg: widths, constants and reset values of the Taylor-series exponential unit.
// No dependencies; imported by exp_taylor_series.
package expts_pkg;

  // Argument and register widths
  localparam int X_W       = 32;            // x in signed Q4.28
  localparam int FRAC_X    = 28;
  localparam int HP_W      = 7;             // highest_power register
  localparam int OUT_W     = 44;            // result in unsigned Q12.32
  localparam int OUT_SHIFT = 8;             // Q23.40 -> Q12.32

  // Series arithmetic
  localparam int SUM_W     = 64;            // signed Q23.40 running sum
  localparam int TMAG_W    = 50;            // term magnitude stays below 2^49
  localparam int MUL_W     = 32;            // shared multiplier operand width
  localparam int HI_W      = TMAG_W;        // upper partial product width
  localparam int Q_W       = 56;            // scaled product before the divide
  localparam int DIV_CHUNK = 8;             // quotient bits per divide cycle
  localparam int DIV_STEPS = Q_W / DIV_CHUNK;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Term count
  localparam int MAX_TERMS = 127;
  localparam int TERM_W    = $clog2(MAX_TERMS + 1);

  localparam logic [HP_W-1:0]  HP_RESET = HP_W'(100);
  localparam logic [SUM_W-1:0] ONE_Q40  = SUM_W'(1) << 40;
  localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};

endpackage

// ===== rtl/exp_taylor_series.sv =====
// exp_taylor_series: e^x by a truncated Taylor series on one shared multiplier and a
// radix-256 divider under a small sequencer. Depends on expts_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall     | in_x_value (signed Q4.28)
//  out     | source    | out_valid / out_stall   | out_exp_value (Q12.32), out_clamped
//  cfg     | sink      | cfg_valid / cfg_ready   | cfg_highest_power (7 bits)
//
// Sequence: for each of the N = highest_power terms, the shared 32x32 multiplier takes the low
//   and then the upper bits of the term, the scaled product is formed, the divider runs and the
//   term is added; the result register then loads, and the next argument is taken after that.
// Reset: rst_n is synchronous, active low; highest_power returns to 100, the sequencer to idle.
// Stalls: the result register holds one transaction, so a new argument is taken while a
//   result waits; the sequencer only waits at its end if the result register is still full and stalled.
module exp_taylor_series
  import expts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // argument channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [X_W-1:0]   in_x_value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_W-1:0]        out_exp_value,
  output logic                    out_clamped,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [HP_W-1:0]         cfg_highest_power
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MLO   = 7'b0000010,
    ST_MHI   = 7'b0000100,
    ST_QFORM = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_ACC   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [HP_W-1:0]     hp_r, hp_nxt;
  logic                xneg_r, xneg_nxt;
  logic [MUL_W-1:0]    xmag_r, xmag_nxt;
  logic                tneg_r, tneg_nxt;
  logic [TMAG_W-1:0]   tmag_r, tmag_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [TERM_W-1:0]   k_r, k_nxt;
  logic [TERM_W-1:0]   n_r, n_nxt;
  logic [2*MUL_W-1:0]  lo_r, lo_nxt;
  logic [HI_W-1:0]     hi_r, hi_nxt;
  logic                pneg_r, pneg_nxt;
  logic [Q_W-1:0]      div_r, div_nxt;
  logic [TERM_W-1:0]   rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_exp_r, out_exp_nxt;
  logic                out_clamp_r, out_clamp_nxt;

  // Shared multiplier: low 32 bits of the term magnitude, then its upper bits.
  logic [MUL_W-1:0]    mul_a;
  logic [2*MUL_W-1:0]  mul_p;

  assign mul_a = (state_r == ST_MLO) ? tmag_r[MUL_W-1:0]
                                     : MUL_W'(tmag_r[TMAG_W-1:MUL_W]);
  assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, xmag_r};

  // Floor of the scaled product; a negative product rounds its magnitude up.
  logic           prod_neg;
  logic           frac_nz;
  logic [Q_W-1:0] q_form;

  assign prod_neg = (tneg_r != xneg_r) && (|tmag_r) && (|xmag_r);
  assign frac_nz  = |lo_r[FRAC_X-1:0];
  assign q_form   = (Q_W'(hi_r) << (MUL_W - FRAC_X)) + Q_W'(lo_r >> FRAC_X)
                  + Q_W'(prod_neg && frac_nz);

  // Divide by k, one byte of quotient per cycle; the remainder never exceeds k.
  logic [TERM_W:0]      dv_rem;
  logic [DIV_CHUNK-1:0] dv_qb;

  always_comb begin
    dv_rem = {1'b0, rem_r};
    dv_qb  = '0;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      dv_rem = {dv_rem[TERM_W-1:0], div_r[Q_W-1-i]};
      if (dv_rem >= {1'b0, k_r}) begin
        dv_rem = dv_rem - {1'b0, k_r};
        dv_qb[DIV_CHUNK-1-i] = 1'b1;
      end
    end
  end

  // Term sign after the divide, and the sum with the new term applied.
  logic             new_tneg;
  logic [SUM_W-1:0] sum_acc;

  assign new_tneg = pneg_r && (|div_r);
  assign sum_acc  = new_tneg ? (sum_r - SUM_W'(div_r)) : (sum_r + SUM_W'(div_r));

  // Clamp Q23.40 to unsigned Q12.32.
  logic [OUT_W-1:0] res_val;
  logic             res_clamp;

  always_comb begin
    priority if (sum_r[SUM_W-1]) begin
      res_val   = '0;
      res_clamp = 1'b1;
    end else if (|sum_r[SUM_W-2:OUT_W+OUT_SHIFT]) begin
      res_val   = OUT_MAX;
      res_clamp = 1'b1;
    end else begin
      res_val   = sum_r[OUT_W+OUT_SHIFT-1:OUT_SHIFT];
      res_clamp = 1'b0;
    end
  end

  logic in_take;
  logic res_load;
  logic [TERM_W-1:0] n_start;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign n_start  = (int'(hp_r) > MAX_TERMS) ? TERM_W'(MAX_TERMS) : TERM_W'(hp_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    hp_nxt        = hp_r;
    xneg_nxt      = xneg_r;
    xmag_nxt      = xmag_r;
    tneg_nxt      = tneg_r;
    tmag_nxt      = tmag_r;
    sum_nxt       = sum_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pneg_nxt      = pneg_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_exp_nxt   = out_exp_r;
    out_clamp_nxt = out_clamp_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid) begin
      hp_nxt = cfg_highest_power;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          xneg_nxt = in_x_value[X_W-1];
          xmag_nxt = in_x_value[X_W-1] ? MUL_W'(-in_x_value) : MUL_W'(in_x_value);
          tneg_nxt = 1'b0;
          tmag_nxt = TMAG_W'(ONE_Q40);
          sum_nxt  = ONE_Q40;
          k_nxt    = TERM_W'(1);
          n_nxt    = n_start;
          state_nxt = (n_start == '0) ? ST_DONE : ST_MLO;
        end
      end
      ST_MLO: begin
        lo_nxt    = mul_p;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        hi_nxt    = mul_p[HI_W-1:0];
        state_nxt = ST_QFORM;
      end
      ST_QFORM: begin
        div_nxt   = q_form;
        pneg_nxt  = prod_neg;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_nxt  = {div_r[Q_W-DIV_CHUNK-1:0], dv_qb};
        rem_nxt  = dv_rem[TERM_W-1:0];
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        tmag_nxt = div_r[TMAG_W-1:0];
        tneg_nxt = new_tneg;
        sum_nxt  = sum_acc;
        if (k_r == n_r) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r + TERM_W'(1);
          state_nxt = ST_MLO;
        end
      end
      ST_DONE: begin
        // hold the finished sum until the result register frees up
        if (res_load) begin
          out_exp_nxt   = res_val;
          out_clamp_nxt = res_clamp;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hp_r        <= HP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hp_r        <= hp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xneg_r      <= xneg_nxt;
    xmag_r      <= xmag_nxt;
    tneg_r      <= tneg_nxt;
    tmag_r      <= tmag_nxt;
    sum_r       <= sum_nxt;
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    pneg_r      <= pneg_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    out_exp_r   <= out_exp_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_exp_value = out_exp_r;
  assign out_clamped   = out_clamp_r;

`ifndef SYNTHESIS
  // An accepted argument starts the first term, or goes straight to the result.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> (state_r == ST_MLO || state_r == ST_DONE))
    else $error("sequencer did not start on an accepted argument");

  // The term index stays in 1..N while terms are being built.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MLO || state_r == ST_ACC) |-> (k_r != '0 && k_r <= n_r))
    else $error("term index out of range");

  // The divider leaves a remainder below the divisor.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> rem_r < k_r)
    else $error("divider remainder not below k");

  // A new result only appears from the final state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result presented outside the final state");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> state_nxt == state_r || state_r != ST_DONE)
    else $error("finished sum left the final state while the result was stalled");
`endif

endmodule
